// ===== src/fswp_pkg.sv =====
// Constants, widths and the arctangent table for the four-step wrapped-phase pipeline.
// Depends on nothing. Used by four_step_wrapped_phase and its testbench.
package fswp_pkg;

    localparam int ANGLE_FRAC_BITS = 13;
    localparam int IN_W            = 8;
    localparam int DIFF_W          = IN_W + 1;
    localparam int ANGLE_W         = 16;

    // CORDIC datapath: x/y scaled by 2^XY_SHIFT, angle held at Z_FRAC fraction bits
    localparam int CORDIC_STAGES = 30;
    localparam int Z_FRAC        = 30;
    localparam int XY_SHIFT      = 20;
    localparam int XY_W          = 32;
    localparam int Z_W           = 35;
    localparam int ROUND_SHIFT   = Z_FRAC - ANGLE_FRAC_BITS;

    localparam longint PI_Z_L = 64'sd3373259426;
    localparam longint PI_F_L = (PI_Z_L + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;

    localparam logic signed [Z_W-1:0] PI_Z       = Z_W'(PI_Z_L);
    localparam logic signed [Z_W-1:0] PI_F       = Z_W'(PI_F_L);
    localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(64'sd1 <<< (ROUND_SHIFT - 1));

    // atan(2^-i) at Z_FRAC fraction bits
    localparam logic [31:0] ATAN_TABLE [CORDIC_STAGES] = '{
        32'h3243F6A9, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h00010000, 32'h00008000,
        32'h00004000, 32'h00002000, 32'h00001000, 32'h00000800,
        32'h00000400, 32'h00000200, 32'h00000100, 32'h00000080,
        32'h00000040, 32'h00000020, 32'h00000010, 32'h00000008,
        32'h00000004, 32'h00000002
    };

endpackage

// ===== src/four_step_wrapped_phase.sv =====
// A beat accepted at the input passes the entry register, the CORDIC stage registers and the output
// register in order. Throughput: one pixel per clock while the output is not stalled, set by the
// one-rotation-per-stage CORDIC pipeline. A stall on the output freezes the whole pipeline and stalls the input.
// Reset (rst_n, asynchronous) clears the valid bits of every stage; payload is not reset.
// Four-step wrapped phase: differences and quadrant fold, 30 vectoring CORDIC stages, rounding.
// Depends on fswp_pkg.
module four_step_wrapped_phase
    import fswp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [IN_W-1:0]           intensity_a,
    input  logic [IN_W-1:0]           intensity_b,
    input  logic [IN_W-1:0]           intensity_c,
    input  logic [IN_W-1:0]           intensity_d,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [ANGLE_W-1:0] wrapped_angle
);

    logic                  adv;

    logic                  valid_reg    [CORDIC_STAGES+1];
    logic                  spec_reg     [CORDIC_STAGES+1];
    logic                  spec_neg_reg [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] x_reg       [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] y_reg       [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]  z_reg       [CORDIC_STAGES+1];

    logic                      out_valid_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic signed [ANGLE_W-1:0] angle_next;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [XY_W-1:0]   x_in_next;
    logic signed [XY_W-1:0]   y_in_next;
    logic signed [Z_W-1:0]    z_in_next;
    logic signed [XY_W-1:0]   x_scaled;
    logic signed [XY_W-1:0]   y_scaled;

    logic signed [Z_W-1:0] round_sum;
    logic signed [Z_W-1:0] rounded;

    // whole pipe moves together; frozen only while a result sits stalled at the output
    assign adv       = !(out_valid_reg && out_stall);
    assign in_stall  = !adv;
    assign out_valid = out_valid_reg;
    assign wrapped_angle = angle_reg;

    // entry stage: differences, scaling, fold the left half-plane by pi
    always_comb
    begin
        dx        = $signed({1'b0, intensity_a}) - $signed({1'b0, intensity_c});
        dy        = $signed({1'b0, intensity_d}) - $signed({1'b0, intensity_b});
        x_scaled  = XY_W'(dx) <<< XY_SHIFT;
        y_scaled  = XY_W'(dy) <<< XY_SHIFT;
        x_in_next = x_scaled;
        y_in_next = y_scaled;
        z_in_next = '0;
        if (dx < 0)
        begin
            x_in_next = -x_scaled;
            y_in_next = -y_scaled;
            z_in_next = (dy > 0) ? PI_Z : -PI_Z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]        <= x_in_next;
            y_reg[0]        <= y_in_next;
            z_reg[0]        <= z_in_next;
            spec_reg[0]     <= (dy == '0);
            spec_neg_reg[0] <= (dx < 0);
        end
    end

    // one micro-rotation per stage
    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        logic signed [Z_W-1:0]  step_ang;
        logic signed [XY_W-1:0] x_next;
        logic signed [XY_W-1:0] y_next;
        logic signed [Z_W-1:0]  z_next;

        always_comb
        begin
            xs       = x_reg[k] >>> k;
            ys       = y_reg[k] >>> k;
            step_ang = $signed(Z_W'(ATAN_TABLE[k]));
            if (y_reg[k] > 0)
            begin
                x_next = x_reg[k] + ys;
                y_next = y_reg[k] - xs;
                z_next = z_reg[k] + step_ang;
            end
            else
            begin
                x_next = x_reg[k] - ys;
                y_next = y_reg[k] + xs;
                z_next = z_reg[k] - step_ang;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[k+1]        <= x_next;
                y_reg[k+1]        <= y_next;
                z_reg[k+1]        <= z_next;
                spec_reg[k+1]     <= spec_reg[k];
                spec_neg_reg[k+1] <= spec_neg_reg[k];
            end
        end
    end

    // round half up, clamp to +-pi; y == 0 bypasses the CORDIC result
    always_comb
    begin
        round_sum = z_reg[CORDIC_STAGES] + ROUND_HALF;
        rounded   = round_sum >>> ROUND_SHIFT;
        if (rounded > PI_F)
        begin
            rounded = PI_F;
        end
        if (rounded < -PI_F)
        begin
            rounded = -PI_F;
        end
        if (spec_reg[CORDIC_STAGES])
        begin
            rounded = spec_neg_reg[CORDIC_STAGES] ? PI_F : '0;
        end
        angle_next = rounded[ANGLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= valid_reg[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            angle_reg <= angle_next;
        end
    end

`ifndef SYNTHESIS
    // after the fold the CORDIC always starts in the right half-plane
    a_fold_right_half: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> !x_reg[0][XY_W-1])
        else $error("x negative after quadrant fold");

    // a non-special beat must carry a nonzero y into the CORDIC
    a_special_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && !spec_reg[0]) |-> (y_reg[0] != '0))
        else $error("special-case flag disagrees with y");

    // a stalled output freezes the last CORDIC stage as well
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(valid_reg[CORDIC_STAGES]))
        else $error("pipeline moved while output stalled");
`endif

endmodule

// ===== tb/sv/tb_four_step_wrapped_phase.sv =====
// Self-checking testbench for four_step_wrapped_phase: drives pixel quads through the
// valid/stall handshake and compares each phase beat with a CORDIC predictor of its own.
// Depends on fswp_pkg and four_step_wrapped_phase.
module tb_four_step_wrapped_phase;
    import fswp_pkg::*;

    localparam int     CYCLE_LIMIT  = 40000;
    localparam int     DRAIN_CYCLES = 48;
    localparam int     RANDOM_PIXELS = 450;
    localparam int     ROTATIONS    = 30;
    localparam int     ANGLE_FRAC_Z = 30;
    localparam int     PIXEL_SCALE  = 20;
    localparam longint PI_AT_Z      = 64'sd3373259426;

    // atan(2^-i) with 30 fraction bits
    localparam longint ATAN_AT_Z [ROTATIONS] = '{
        64'h3243F6A9, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h00010000, 64'h00008000,
        64'h00004000, 64'h00002000, 64'h00001000, 64'h00000800,
        64'h00000400, 64'h00000200, 64'h00000100, 64'h00000080,
        64'h00000040, 64'h00000020, 64'h00000010, 64'h00000008,
        64'h00000004, 64'h00000002
    };

    typedef struct packed {
        logic [IN_W-1:0] a;
        logic [IN_W-1:0] b;
        logic [IN_W-1:0] c;
        logic [IN_W-1:0] d;
    } pixel_quad_t;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    logic [IN_W-1:0]           intensity_a = '0;
    logic [IN_W-1:0]           intensity_b = '0;
    logic [IN_W-1:0]           intensity_c = '0;
    logic [IN_W-1:0]           intensity_d = '0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    logic signed [ANGLE_W-1:0] wrapped_angle;

    pixel_quad_t               pending_pixels [$];
    logic signed [ANGLE_W-1:0] expected_angles [$];
    int                        mismatch_count = 0;
    int                        cycle_count    = 0;

    four_step_wrapped_phase dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .intensity_a   (intensity_a),
        .intensity_b   (intensity_b),
        .intensity_c   (intensity_c),
        .intensity_d   (intensity_d),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .wrapped_angle (wrapped_angle)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // atan2(d - b, a - c) by vectoring CORDIC, rounded half up and clamped to +-pi
    function automatic logic signed [ANGLE_W-1:0] phase_of_pixel(input pixel_quad_t px);
        longint y;
        longint x;
        longint z;
        longint xs;
        longint ys;
        longint pi_out;
        longint angle;
        int     drop;
        y      = longint'(px.d) - longint'(px.b);
        x      = longint'(px.a) - longint'(px.c);
        drop   = ANGLE_FRAC_Z - ANGLE_FRAC_BITS;
        pi_out = (PI_AT_Z + (64'sd1 <<< (drop - 1))) >>> drop;
        z      = 0;
        if (y == 0)
        begin
            angle = (x < 0) ? pi_out : 0;
        end
        else
        begin
            x = x <<< PIXEL_SCALE;
            y = y <<< PIXEL_SCALE;
            // left half-plane: turn by pi first
            if (x < 0)
            begin
                z = (y > 0) ? PI_AT_Z : -PI_AT_Z;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < ROTATIONS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_AT_Z[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_AT_Z[i];
                end
            end
            angle = (z + (64'sd1 <<< (drop - 1))) >>> drop;
            if (angle > pi_out)
                angle = pi_out;
            if (angle < -pi_out)
                angle = -pi_out;
        end
        return angle[ANGLE_W-1:0];
    endfunction

    // ~23 % idle cycles, none in a quiet window early in the run
    function automatic bit take_break();
        if (cycle_count >= 200 && cycle_count < 600)
            return 1'b0;
        return $urandom_range(99) < 23;
    endfunction

    task automatic add_pixel(input int a, input int b, input int c, input int d);
        pending_pixels.insert(pending_pixels.size(),
            pixel_quad_t'{a[IN_W-1:0], b[IN_W-1:0], c[IN_W-1:0], d[IN_W-1:0]});
    endtask

    function automatic int near_value(input int base);
        int v;
        v = base + int'($urandom_range(6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v;
    endfunction

    // input side: the beat on the bus is always the head of pending_pixels
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_angles.insert(expected_angles.size(), phase_of_pixel(
                    pixel_quad_t'{intensity_a, intensity_b, intensity_c, intensity_d}));
                pending_pixels.delete(0);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_pixels.size() != 0 && !take_break())
                begin
                    in_valid    <= 1'b1;
                    intensity_a <= pending_pixels[0].a;
                    intensity_b <= pending_pixels[0].b;
                    intensity_c <= pending_pixels[0].c;
                    intensity_d <= pending_pixels[0].d;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_angles.size() == 0)
                begin
                    $display("%0t: unexpected wrapped_angle beat, expected none, got %0d",
                             $time, wrapped_angle);
                    mismatch_count++;
                end
                else
                begin
                    if (wrapped_angle !== expected_angles[0])
                    begin
                        $display("%0t: wrapped_angle expected %0d, got %0d",
                                 $time, expected_angles[0], wrapped_angle);
                        mismatch_count++;
                    end
                    expected_angles.delete(0);
                end
            end
            out_stall <= take_break();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels unsent, %0d angles outstanding",
                     cycle_count, pending_pixels.size(), expected_angles.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int kind;
        int base;
        int other;

        // zero vector, both axes, all four quadrants
        add_pixel(0, 0, 0, 0);
        add_pixel(255, 255, 255, 255);
        add_pixel(255, 7, 0, 7);        // y zero, x positive
        add_pixel(0, 200, 255, 200);    // y zero, x negative: +pi
        add_pixel(128, 0, 128, 255);    // x zero, y positive
        add_pixel(128, 255, 128, 0);    // x zero, y negative
        add_pixel(255, 0, 0, 255);
        add_pixel(255, 255, 0, 0);
        add_pixel(0, 0, 255, 255);      // left half, y positive
        add_pixel(0, 255, 255, 0);      // left half, y negative
        add_pixel(0, 0, 255, 1);        // just below +pi
        add_pixel(0, 1, 255, 0);        // just above -pi
        add_pixel(0, 100, 1, 101);
        add_pixel(0, 101, 1, 100);
        add_pixel(1, 0, 0, 255);
        add_pixel(1, 255, 0, 0);
        add_pixel(255, 0, 0, 1);
        add_pixel(170, 85, 85, 170);
        add_pixel(85, 170, 170, 85);
        add_pixel(10, 20, 30, 40);

        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            kind  = $urandom_range(3);
            base  = $urandom_range(255);
            other = $urandom_range(255);
            case (kind)
                2: add_pixel(base, other, near_value(base), $urandom_range(255));
                3: add_pixel(other, base, $urandom_range(255), near_value(base));
                default: add_pixel($urandom_range(255), $urandom_range(255),
                                   $urandom_range(255), $urandom_range(255));
            endcase
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_pixels.size() != 0 || expected_angles.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
